>>> design/sal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sal_pkg
// Types, operation codes and defaults shared by the sorted list block.
// ----------------------------------------------------------------------------
package sal_pkg;

  localparam int DEPTH_DEF       = 64;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int ACTION_W = 3;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 7;
  localparam int STATUS_W = 2;

  localparam logic [ACTION_W-1:0] ACT_INSERT  = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_DELETE  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_SEARCH  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_CLEAR   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RESTART = 3'd4;
  localparam logic [ACTION_W-1:0] ACT_NEXT    = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [STATUS_W-1:0] ST_PAST_END  = 2'd3;

  typedef struct packed {
    logic [ACTION_W-1:0]      action;
    logic signed [DATA_W-1:0] value;
  } sal_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] read_value;
    logic                     found;
    logic [COUNT_W-1:0]       entry_count;
    logic                     is_full;
    logic                     empty_flag;
    logic [STATUS_W-1:0]      status;
  } sal_out_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic cmp;  // latch compare flags against the incoming value
    logic ins;  // insert shift toward higher index
    logic del;  // delete shift toward lower index
  } sal_cmd_t;

endpackage
`default_nettype wire

>>> design/sorted_array_list.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_array_list
// Sorted store of signed values kept in a row of compare-and-shift cells.
// Input channel (in_valid_i/in_ready_o/in_item_i) carries one operation per
// item: insert, delete, search, clear, restart walk, read next. Output channel
// (out_valid_o/out_ready_i/out_item_o) returns exactly one result item per
// operation with the count, full/empty flags and a status code.
// Each item is handled in a compare step and then a shift step: in the accept
// cycle every cell compares its entry with the operand and latches its flags;
// once the output register is free, the cells shift in place and the result
// is loaded into the output register. A new item is accepted only after the
// current one commits, set by the compare-then-shift pass through the cell row.
// Reset empties the store and sets the walk position to zero; entry contents
// are left as they are. If the receiver stalls, the finished result waits in
// the output register while the next item is accepted and compared; that
// item commits once the output register is free.
// ----------------------------------------------------------------------------
module sorted_array_list
  import sal_pkg::*;
#(
  parameter int DEPTH       = DEPTH_DEF,
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire sal_in_t  in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output sal_out_t      out_item_o
);

  localparam int CW = $clog2(DEPTH + 1);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_BUSY = 1'b1;

  logic state_q, state_d;
  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] walk_q, walk_d;
  logic out_valid_q;
  sal_out_t out_q, res;
  logic [ACTION_W-1:0] op_q;
  logic [VALUE_WIDTH-1:0] v_q, cmp_v;

  logic accept_in, out_free, commit, ins, del, found;
  sal_cmd_t cmd;

  logic [VALUE_WIDTH-1:0] e_arr  [DEPTH];
  logic [VALUE_WIDTH-1:0] rd_arr [DEPTH];
  logic [DEPTH-1:0] gt_vec, eq_vec;
  logic [VALUE_WIDTH-1:0] rd_all;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept_in  = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign commit     = (state_q == S_BUSY) && out_free;
  assign cmp_v      = VALUE_WIDTH'($unsigned(in_item_i.value));

  assign cmd.cmp = accept_in;
  assign cmd.ins = commit && ins;
  assign cmd.del = commit && del;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic                   left_gt;
    logic [VALUE_WIDTH-1:0] left_e, right_e;

    if (i == 0) begin : g_first
      assign left_gt = 1'b0;
      assign left_e  = '0;
    end else begin : g_mid
      assign left_gt = gt_vec[i-1];
      assign left_e  = e_arr[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_e = e_arr[i];
    end else begin : g_inner
      assign right_e = e_arr[i+1];
    end

    sal_cell #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_cell (
      .clk_i    (clk_i),
      .cmd_i    (cmd),
      .live_i   (CW'(i) < count_q),
      .pick_i   (walk_q == CW'(i)),
      .cmp_v_i  (cmp_v),
      .new_v_i  (v_q),
      .left_gt_i(left_gt),
      .left_e_i (left_e),
      .right_e_i(right_e),
      .e_o      (e_arr[i]),
      .gt_o     (gt_vec[i]),
      .eq_o     (eq_vec[i]),
      .rd_o     (rd_arr[i])
    );
  end

  always_comb begin
    rd_all = '0;
    for (int k = 0; k < DEPTH; k++) begin
      rd_all = rd_all | rd_arr[k];
    end
  end

  assign found = |eq_vec;

  always_comb begin
    count_d = count_q;
    walk_d  = walk_q;
    ins     = 1'b0;
    del     = 1'b0;
    res     = '0;
    res.status = ST_OK;
    case (op_q)
      ACT_INSERT: begin
        if (count_q == CW'(DEPTH)) begin
          res.status = ST_FULL;
        end else begin
          ins     = 1'b1;
          count_d = count_q + 1'b1;
        end
      end
      ACT_DELETE: begin
        if (found) begin
          del       = 1'b1;
          count_d   = count_q - 1'b1;
          res.found = 1'b1;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      ACT_SEARCH: begin
        if (found) begin
          res.found = 1'b1;
        end else begin
          res.status = ST_NOT_FOUND;
        end
      end
      ACT_CLEAR: begin
        count_d = '0;
      end
      ACT_RESTART: begin
        walk_d = '0;
      end
      ACT_NEXT: begin
        if (walk_q < count_q) begin
          res.read_value = DATA_W'(signed'(rd_all));
          walk_d         = walk_q + 1'b1;
        end else begin
          res.status = ST_PAST_END;
        end
      end
      default: ;
    endcase
    res.entry_count = COUNT_W'(count_d);
    res.is_full     = (count_d == CW'(DEPTH));
    res.empty_flag  = (count_d == '0);
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (accept_in) state_d = S_BUSY;
      S_BUSY: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      walk_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (commit) begin
        count_q     <= count_d;
        walk_q      <= walk_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      op_q <= in_item_i.action;
      v_q  <= cmp_v;
    end
    if (commit) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

>>> design/sal_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sal_cell
// One slot of the sorted row: holds an entry, latches its compare flags and
// shifts with its neighbors on insert or delete.
// ----------------------------------------------------------------------------
module sal_cell
  import sal_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk_i,
  input  wire sal_cmd_t               cmd_i,
  input  wire logic                   live_i,
  input  wire logic                   pick_i,
  input  wire logic [VALUE_WIDTH-1:0] cmp_v_i,
  input  wire logic [VALUE_WIDTH-1:0] new_v_i,
  input  wire logic                   left_gt_i,
  input  wire logic [VALUE_WIDTH-1:0] left_e_i,
  input  wire logic [VALUE_WIDTH-1:0] right_e_i,
  output logic [VALUE_WIDTH-1:0]      e_o,
  output logic                        gt_o,
  output logic                        eq_o,
  output logic [VALUE_WIDTH-1:0]      rd_o
);

  logic [VALUE_WIDTH-1:0] e_q;
  logic gt_q, ge_q, eq_q, pick_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.cmp) begin
      // empty slots count as greater so the insert point is the first set gt
      gt_q   <= !live_i || ($signed(e_q) > $signed(cmp_v_i));
      ge_q   <= $signed(e_q) >= $signed(cmp_v_i);
      eq_q   <= live_i && (e_q == cmp_v_i);
      pick_q <= pick_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ins && gt_q) begin
      e_q <= left_gt_i ? left_e_i : new_v_i;
    end else if (cmd_i.del && ge_q) begin
      e_q <= right_e_i;
    end
  end

  assign e_o  = e_q;
  assign gt_o = gt_q;
  assign eq_o = eq_q;
  assign rd_o = pick_q ? e_q : '0;

endmodule
`default_nettype wire

>>> test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the sorted list block end to end. An initial block queues directed
// and random list operations. A clocked driver offers them on the input
// channel, and a clocked monitor takes results with random back-pressure.
// Each accepted operation is applied to a local sorted list. The result that
// the list gives is compared with the block's result, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import sal_pkg::*;

  localparam int                  LIST_DEPTH  = DEPTH_DEF;
  localparam int                  STALL_LEN   = 300;
  localparam int                  CYCLE_LIMIT = 100000;
  localparam logic [ACTION_W-1:0] ACT_SPARE_A = 3'd6;
  localparam logic [ACTION_W-1:0] ACT_SPARE_B = 3'd7;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  sal_in_t  in_item = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  sal_out_t out_item;

  sal_in_t  op_q[$];
  sal_out_t list_result_q[$];

  logic signed [DATA_W-1:0] list_mem[LIST_DEPTH];
  int       list_cnt;
  int       walk_pos;

  int       snd_idle_pct = 0;
  int       rcv_idle_pct = 0;
  int       stall_req = 0;
  int       stall_seen;
  int       stall_left;
  int       err_cnt = 0;
  int       cycle_cnt = 0;

  sorted_array_list u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic sal_out_t list_apply(input sal_in_t op);
    sal_out_t r;
    int pos;
    r = '0;
    r.status = ST_OK;
    case (op.action)
      ACT_INSERT: begin
        if (list_cnt >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < list_cnt && !(list_mem[pos] > op.value)) pos++;
          for (int j = list_cnt; j > pos; j--) list_mem[j] = list_mem[j-1];
          list_mem[pos] = op.value;
          list_cnt++;
        end
      end
      ACT_DELETE, ACT_SEARCH: begin
        pos = 0;
        while (pos < list_cnt && list_mem[pos] != op.value) pos++;
        if (pos >= list_cnt) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.found = 1'b1;
          if (op.action == ACT_DELETE) begin
            for (int j = pos; j + 1 < list_cnt; j++) list_mem[j] = list_mem[j+1];
            list_cnt--;
          end
        end
      end
      ACT_CLEAR: list_cnt = 0;
      ACT_RESTART: walk_pos = 0;
      ACT_NEXT: begin
        if (walk_pos < list_cnt) begin
          r.read_value = list_mem[walk_pos];
          walk_pos++;
        end else begin
          r.status = ST_PAST_END;
        end
      end
      default: ;
    endcase
    r.entry_count = list_cnt[COUNT_W-1:0];
    r.is_full     = (list_cnt == LIST_DEPTH);
    r.empty_flag  = (list_cnt == 0);
    return r;
  endfunction

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      list_cnt = 0;
      walk_pos = 0;
    end else begin
      if (in_valid && in_ready) list_result_q.push_back(list_apply(in_item));
      if (!in_valid || in_ready) begin
        if (op_q.size() > 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
          in_item  <= op_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_result(input sal_out_t got);
    sal_out_t exp_r;
    if (list_result_q.size() == 0) begin
      $error("unexpected result item: %p", got);
      err_cnt++;
    end else begin
      exp_r = list_result_q.pop_front();
      if (got.read_value !== exp_r.read_value) begin
        $error("read_value: expected %0d, got %0d", exp_r.read_value, got.read_value);
        err_cnt++;
      end
      if (got.found !== exp_r.found) begin
        $error("found: expected %0d, got %0d", exp_r.found, got.found);
        err_cnt++;
      end
      if (got.entry_count !== exp_r.entry_count) begin
        $error("entry_count: expected %0d, got %0d", exp_r.entry_count, got.entry_count);
        err_cnt++;
      end
      if (got.is_full !== exp_r.is_full) begin
        $error("is_full: expected %0d, got %0d", exp_r.is_full, got.is_full);
        err_cnt++;
      end
      if (got.empty_flag !== exp_r.empty_flag) begin
        $error("empty_flag: expected %0d, got %0d", exp_r.empty_flag, got.empty_flag);
        err_cnt++;
      end
      if (got.status !== exp_r.status) begin
        $error("status: expected %0d, got %0d", exp_r.status, got.status);
        err_cnt++;
      end
    end
  endtask

  // monitor
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      stall_seen <= 0;
      stall_left <= 0;
    end else begin
      if (out_valid && out_ready) check_result(out_item);
      if (stall_seen != stall_req) begin
        stall_seen <= stall_req;
        stall_left <= STALL_LEN;
        out_ready  <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_ready  <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic add_op(input logic [ACTION_W-1:0] act, input logic signed [DATA_W-1:0] v);
    sal_in_t op;
    op.action = act;
    op.value  = v;
    op_q.push_back(op);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 3))
      0, 1: v = $signed($urandom_range(0, 16)) - 8;
      2: v = $urandom;
      default: begin
        case ($urandom_range(0, 3))
          0: v = {1'b0, {(DATA_W-1){1'b1}}};
          1: v = {1'b1, {(DATA_W-1){1'b0}}};
          2: v = '1;
          default: v = '0;
        endcase
      end
    endcase
    return v;
  endfunction

  task automatic add_random_ops(input int n);
    int made;
    int len;
    made = 0;
    while (made < n) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: begin
          len = $urandom_range(4, 20);
          repeat (len) add_op(ACT_INSERT, pick_value());
        end
        4: begin
          len = LIST_DEPTH + 4;
          repeat (len) add_op(ACT_INSERT, pick_value());
        end
        5, 6: begin
          len = $urandom_range(2, 20);
          add_op(ACT_RESTART, pick_value());
          repeat (len - 1) add_op(ACT_NEXT, pick_value());
        end
        7, 8: begin
          len = $urandom_range(3, 10);
          repeat (len) add_op($urandom_range(0, 1) ? ACT_DELETE : ACT_SEARCH, pick_value());
        end
        9: begin
          len = 1;
          add_op($urandom_range(0, 2) == 0 ? ACT_CLEAR : ACT_SEARCH, pick_value());
        end
        default: begin
          len = $urandom_range(3, 8);
          repeat (len) add_op(ACTION_W'($urandom_range(0, 7)), $urandom);
        end
      endcase
      made += len;
    end
  endtask

  task automatic wait_drained();
    while (op_q.size() > 0 || in_valid || list_result_q.size() > 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty store, extremes, duplicates, misses, walk, clear
    add_op(ACT_NEXT, 0);
    add_op(ACT_SEARCH, 5);
    add_op(ACT_DELETE, 5);
    add_op(ACT_INSERT, 0);
    add_op(ACT_INSERT, {1'b0, {(DATA_W-1){1'b1}}});
    add_op(ACT_INSERT, {1'b1, {(DATA_W-1){1'b0}}});
    add_op(ACT_INSERT, -1);
    add_op(ACT_INSERT, 1);
    add_op(ACT_INSERT, 0);
    add_op(ACT_SEARCH, {1'b0, {(DATA_W-1){1'b1}}});
    add_op(ACT_SEARCH, 7);
    add_op(ACT_DELETE, 0);
    add_op(ACT_DELETE, 7);
    add_op(ACT_SPARE_A, -1);
    add_op(ACT_SPARE_B, 0);
    add_op(ACT_RESTART, 0);
    repeat (6) add_op(ACT_NEXT, 0);
    add_op(ACT_CLEAR, 0);
    add_op(ACT_NEXT, 0);
    add_op(ACT_RESTART, 0);
    add_op(ACT_NEXT, 0);

    snd_idle_pct = 17;
    rcv_idle_pct = 76;
    add_random_ops(200);
    wait_drained();

    snd_idle_pct = 76;
    rcv_idle_pct = 17;
    add_random_ops(200);
    wait_drained();

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    add_random_ops(200);
    stall_req = stall_req + 1;
    wait_drained();

    repeat (10) @(negedge clk_i);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
